// ----- design/pcfs_pkg.sv -----
// Shared types and constants for the point charge field sum block.
`timescale 1ns / 1ps
package pcfs_pkg;
    localparam int CoordW = 24;
    localparam int DiffW  = 25;
    localparam int SsqW   = 51;
    localparam int RootW  = 26;
    localparam int R2W    = 52;
    localparam int NumW   = 64;
    localparam int SumW   = 64;
    localparam int OutW   = 48;
    localparam int CountW = 7;

    // Request codes.
    localparam logic ReqLoad  = 1'b0;
    localparam logic ReqQuery = 1'b1;

    // Command to the shared divider.
    typedef struct packed {
        logic            start;
        logic [NumW-1:0] num;
        logic [R2W-1:0]  den;
    } t_div_cmd;

    // Status from the shared divider.
    typedef struct packed {
        logic            done;
        logic [NumW-1:0] quot;
    } t_div_sts;
endpackage

// ----- design/pcfs_isqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module pcfs_isqrt
    import pcfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SsqW-1:0]   i_value,
    output logic              o_done,
    output logic [RootW-1:0]  o_root
);
    // Remainder and partial root; one root bit per cycle.
    logic [SsqW+1:0]  r_rem, n_rem;
    logic [RootW-1:0] r_root, n_root;
    logic [SsqW+1:0]  r_val, n_val;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [SsqW+1:0]  trial;

    always_comb begin
        n_rem  = r_rem;
        n_root = r_root;
        n_val  = r_val;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = '0;
        if (i_start) begin
            n_rem  = '0;
            n_root = '0;
            n_val  = {1'b0, i_value, 1'b0};
            n_cnt  = 5'(RootW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Bring down two bits and try the next root bit.
            n_rem = {r_rem[SsqW-1:0], r_val[SsqW+1:SsqW]};
            n_val = {r_val[SsqW-1:0], 2'b00};
            trial = {(SsqW + 2 - RootW - 2)'(0), r_root, 2'b01};
            if (n_rem >= trial) begin
                n_rem  = n_rem - trial;
                n_root = {r_root[RootW-2:0], 1'b1};
            end else begin
                n_root = {r_root[RootW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_val  <= n_val;
        r_cnt  <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- design/pcfs_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcfs_div
    import pcfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_cmd i_cmd,
    output t_div_sts o_sts
);
    logic [R2W:0]    r_rem, n_rem;
    logic [NumW-1:0] r_quo, n_quo;
    logic [R2W-1:0]  r_den, n_den;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [R2W:0]    shifted;

    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        shifted = '0;
        if (i_cmd.start) begin
            n_rem  = '0;
            n_quo  = i_cmd.num;
            n_den  = i_cmd.den;
            n_cnt  = 6'(NumW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Shift in the next dividend bit and subtract when it fits.
            shifted = {r_rem[R2W-1:0], r_quo[NumW-1]};
            if (shifted >= {1'b0, r_den}) begin
                n_rem = shifted - {1'b0, r_den};
                n_quo = {r_quo[NumW-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[NumW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.quot = r_quo;
endmodule

// ----- design/point_charge_field_sum.sv -----
// Top level of the point charge field sum: particle store, sequencer and shared units.
// Throughput: one item at a time; busy stays high until the cycle the field word is strobed.
// Each particle passes through the read, difference and square steps, the root, and one division per axis.
// Reset is synchronous and active low; it clears the count and the sequencer, not the store.
// The receiver cannot stall; a result word is strobed for exactly one cycle.
`timescale 1ns / 1ps
module point_charge_field_sum
    import pcfs_pkg::*;
#(
    parameter int PARTICLES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_req_type,
    input  logic [5:0]               i_slot,
    input  logic signed [CoordW-1:0] i_coord_x,
    input  logic signed [CoordW-1:0] i_coord_y,
    input  logic signed [CoordW-1:0] i_coord_z,
    input  logic signed [CoordW-1:0] i_charge,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CountW-1:0]        i_cfg_data,
    output logic                     o_strobe,
    output logic signed [OutW-1:0]   o_field_x,
    output logic signed [OutW-1:0]   o_field_y,
    output logic signed [OutW-1:0]   o_field_z,
    output logic                     o_saturated
);
    localparam int AddrW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_READ = 10'b0000000010,
        S_DIFF = 10'b0000000100,
        S_SQ   = 10'b0000001000,
        S_ROOT = 10'b0000010000,
        S_R2   = 10'b0000100000,
        S_NUM  = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_NEXT = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // Particle store, one word per slot.
    logic [4*CoordW-1:0] r_mem [PARTICLES];
    logic [4*CoordW-1:0] r_rd;

    logic [CountW-1:0]        r_count;
    logic signed [CoordW-1:0] r_px, r_py, r_pz;
    logic [AddrW:0]           r_idx, n_idx;
    logic [AddrW:0]           r_lim;
    logic signed [DiffW-1:0]  r_d [3];
    logic [DiffW-1:0]         r_ad [3];
    logic signed [CoordW-1:0] r_q;
    logic [1:0]               r_ax, n_ax;
    logic [SsqW-1:0]          ssq;
    logic [R2W-1:0]           r_r2;
    logic signed [SumW-1:0]   r_sum [3];
    logic                     r_strobe;
    logic signed [OutW-1:0]   r_fx, r_fy, r_fz;
    logic                     r_sat;

    logic             sq_start, sq_done;
    logic [RootW-1:0] sq_root;
    t_div_cmd         div_cmd;
    t_div_sts         div_sts;
    logic [DiffW-1:0] aq;
    logic [47:0]      prod;
    logic [RootW:0]   rr;
    logic signed [SumW-1:0] term;
    logic             neg;

    logic accept;

    function automatic logic ovf(input logic signed [SumW-1:0] v);
        ovf = (v[SumW-1:OutW-1] != '0) && (v[SumW-1:OutW-1] != '1);
    endfunction

    function automatic logic signed [OutW-1:0] clip(input logic signed [SumW-1:0] v);
        if (!ovf(v)) clip = v[OutW-1:0];
        else if (v[SumW-1]) clip = {1'b1, {(OutW-1){1'b0}}};
        else clip = {1'b0, {(OutW-1){1'b1}}};
    endfunction

    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // Store writes on load and registered store reads.
    always_ff @(posedge i_clk) begin
        if (accept && i_req_type == ReqLoad && int'(i_slot) < PARTICLES) begin
            r_mem[AddrW'(i_slot)] <= {i_coord_x, i_coord_y, i_coord_z, i_charge};
        end
        r_rd <= r_mem[r_idx[AddrW-1:0]];
    end

    // Next-state sequencing.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_ax    = r_ax;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept && i_req_type == ReqQuery) begin
                    n_state = S_NEXT;
                end
            end
            S_READ: n_state = S_DIFF;
            S_DIFF: n_state = S_SQ;
            S_SQ:   n_state = S_ROOT;
            S_ROOT: if (sq_done) n_state = S_R2;
            S_R2: begin
                n_ax    = 2'd0;
                n_state = S_NUM;
            end
            S_NUM:  n_state = S_DIV;
            S_DIV: begin
                if (div_sts.done) begin
                    if (r_ax == 2'd2) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_NEXT;
                    end else begin
                        n_ax    = r_ax + 2'd1;
                        n_state = S_NUM;
                    end
                end
            end
            S_NEXT: n_state = (r_idx == r_lim) ? S_OUT : S_READ;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Squared distance, fed straight into the square root as it starts.
    assign ssq = SsqW'(r_ad[0] * r_ad[0]) + SsqW'(r_ad[1] * r_ad[1])
               + SsqW'(r_ad[2] * r_ad[2]);

    // Product for the current axis and signed quotient.
    assign aq   = r_q[CoordW-1] ? DiffW'(-{r_q[CoordW-1], r_q}) : DiffW'({1'b0, r_q});
    assign prod = 48'(r_ad[r_ax] * aq);
    assign rr   = {1'b0, sq_root} + 1'b1;
    assign neg  = r_d[r_ax][DiffW-1] != r_q[CoordW-1];
    assign term = neg ? -$signed(div_sts.quot) : $signed(div_sts.quot);

    assign sq_start      = (r_state == S_SQ);
    assign div_cmd.start = (r_state == S_NUM);
    assign div_cmd.num   = {prod, 16'd0};
    assign div_cmd.den   = r_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_ax     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ax     <= n_ax;
            if (i_cfg_valid && o_cfg_ready) r_count <= i_cfg_data;
            r_strobe <= (r_state == S_OUT);
        end

        // Latch the query point and particle limit and clear the sums.
        if (accept && i_req_type == ReqQuery) begin
            r_px  <= i_coord_x;
            r_py  <= i_coord_y;
            r_pz  <= i_coord_z;
            r_lim <= (int'(r_count) > PARTICLES) ? (AddrW+1)'(PARTICLES)
                                                 : (AddrW+1)'(r_count);
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
        end

        // Differences and the particle charge; the magnitudes are taken combinationally below.
        if (r_state == S_DIFF) begin
            r_d[0] <= DiffW'(r_px) - DiffW'($signed(r_rd[4*CoordW-1:3*CoordW]));
            r_d[1] <= DiffW'(r_py) - DiffW'($signed(r_rd[3*CoordW-1:2*CoordW]));
            r_d[2] <= DiffW'(r_pz) - DiffW'($signed(r_rd[2*CoordW-1:CoordW]));
            r_q    <= r_rd[CoordW-1:0];
        end
        if (r_state == S_R2) r_r2 <= R2W'(rr * rr);

        // Accumulate each finished quotient.
        if (r_state == S_DIV && div_sts.done) r_sum[r_ax] <= r_sum[r_ax] + term;

        // Clip the sums into the output word.
        if (r_state == S_OUT) begin
            r_fx  <= clip(r_sum[0]);
            r_fy  <= clip(r_sum[1]);
            r_fz  <= clip(r_sum[2]);
            r_sat <= ovf(r_sum[0]) || ovf(r_sum[1]) || ovf(r_sum[2]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_ad[k] = r_d[k][DiffW-1] ? DiffW'(-r_d[k]) : DiffW'(r_d[k]);
        end
    end

    pcfs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (ssq),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    pcfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_sts   (div_sts)
    );

    assign o_strobe    = r_strobe;
    assign o_field_x   = r_fx;
    assign o_field_y   = r_fy;
    assign o_field_z   = r_fz;
    assign o_saturated = r_sat;
endmodule
